### hdl/pbpp_pkg.sv
// Package for the pixel bit-plane packer: payload structs, configuration
// register codes and the queue entry format. No dependencies.
`timescale 1ns / 1ps

package pbpp_pkg;

  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned MAX_BITS   = 32;
  localparam int unsigned NBITS_W    = 6;
  localparam int unsigned BUF_W      = 39;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE          = 3'd0,
    REG_CHANNEL_COUNT = 3'd1,
    REG_CHANNEL_0     = 3'd2,
    REG_CHANNEL_1     = 3'd3,
    REG_CHANNEL_2     = 3'd4,
    REG_CHANNEL_3     = 3'd5,
    REG_BITS_PER_CHAN = 3'd6,
    REG_PLANE_BIT     = 3'd7
  } cfg_reg_e;

  localparam logic MODE_PLANE    = 1'b0;
  localparam logic MODE_LOW_BITS = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       last_byte;
  } result_t;

  typedef struct packed {
    logic       mode;
    logic [2:0] channel_count;
    logic [1:0] channel_0;
    logic [1:0] channel_1;
    logic [1:0] channel_2;
    logic [1:0] channel_3;
    logic [3:0] bits_per_channel;
    logic [2:0] plane_bit;
  } cfg_t;

  typedef struct packed {
    logic [MAX_BITS-1:0] bits;
    logic [NBITS_W-1:0]  nbits;
    logic                last;
  } entry_t;

  function automatic logic [7:0] pick_channel(pixel_t p, logic [1:0] sel);
    logic [7:0] v;
    case (sel)
      2'd0:    v = p.red;
      2'd1:    v = p.green;
      2'd2:    v = p.blue;
      default: v = p.alpha;
    endcase
    return v;
  endfunction

endpackage

### hdl/pixel_bit_plane_packer_top.sv
// The first byte of a pixel is registered in the queue and then in the back
// part's output register. Throughput: one byte beat per cycle while
// result_stall is low, from the back part's single output path. Reset
// restores register defaults, empties the queue and drops pending bits.
// Depends on pbpp_pkg, pbpp_front, pbpp_fifo, pbpp_back.
`timescale 1ns / 1ps

module pixel_bit_plane_packer_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pixel_valid,
  output logic                                 pixel_stall,
  input  pbpp_pkg::pixel_t                     pixel,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output pbpp_pkg::result_t                    result,
  input  logic                                 cfg_write,
  input  logic [pbpp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pbpp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import pbpp_pkg::*;

  cfg_t   cfg;
  entry_t front_entry;
  entry_t q_entry;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;
  logic   push;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode             <= MODE_LOW_BITS;
      cfg.channel_count    <= 3'd3;
      cfg.channel_0        <= 2'd0;
      cfg.channel_1        <= 2'd1;
      cfg.channel_2        <= 2'd2;
      cfg.channel_3        <= 2'd3;
      cfg.bits_per_channel <= 4'd1;
      cfg.plane_bit        <= 3'd0;
    end else if (cfg_write) begin
      case (cfg_reg_e'(cfg_index))
        REG_MODE:          cfg.mode             <= cfg_data[0];
        REG_CHANNEL_COUNT: cfg.channel_count    <= cfg_data[2:0];
        REG_CHANNEL_0:     cfg.channel_0        <= cfg_data[1:0];
        REG_CHANNEL_1:     cfg.channel_1        <= cfg_data[1:0];
        REG_CHANNEL_2:     cfg.channel_2        <= cfg_data[1:0];
        REG_CHANNEL_3:     cfg.channel_3        <= cfg_data[1:0];
        REG_BITS_PER_CHAN: cfg.bits_per_channel <= cfg_data[3:0];
        REG_PLANE_BIT:     cfg.plane_bit        <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  assign pixel_stall = q_full;
  assign push        = pixel_valid && !q_full;

  pbpp_front u_front (
    .cfg   (cfg),
    .pixel (pixel),
    .entry (front_entry)
  );

  pbpp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_entry),
    .not_empty (q_valid)
  );

  pbpp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_entry      (q_entry),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### hdl/pbpp_front.sv
// Front part of the packer: extracts the bit stream of one pixel into a
// right-aligned word with its bit count. Depends on pbpp_pkg.
`timescale 1ns / 1ps

module pbpp_front (
  input  pbpp_pkg::cfg_t   cfg,
  input  pbpp_pkg::pixel_t pixel,
  output pbpp_pkg::entry_t entry
);
  import pbpp_pkg::*;

  logic [2:0]          cnt;
  logic [3:0]          nb;
  logic [7:0]          mask;
  logic [1:0]          sel [4];
  logic [MAX_BITS-1:0] word;
  logic [7:0]          plane_src;

  assign sel[0] = cfg.channel_0;
  assign sel[1] = cfg.channel_1;
  assign sel[2] = cfg.channel_2;
  assign sel[3] = cfg.channel_3;

  always_comb begin
    cnt = cfg.channel_count;
    if (cnt == 3'd0) begin
      cnt = 3'd1;
    end else if (cnt > 3'd4) begin
      cnt = 3'd4;
    end
    nb = cfg.bits_per_channel;
    if (nb == 4'd0) begin
      nb = 4'd1;
    end else if (nb > 4'd8) begin
      nb = 4'd8;
    end
    mask = 8'hFF >> (4'd8 - nb);
    word = '0;
    for (int s = 0; s < 4; s++) begin
      if (3'(s) < cnt) begin
        word = (word << nb) | MAX_BITS'(pick_channel(pixel, sel[s]) & mask);
      end
    end
    plane_src = pick_channel(pixel, cfg.channel_0) >> cfg.plane_bit;
    entry.last = pixel.last_pixel;
    if (cfg.mode == MODE_PLANE) begin
      entry.bits  = MAX_BITS'(plane_src[0]);
      entry.nbits = NBITS_W'(1);
    end else begin
      entry.bits  = word;
      entry.nbits = NBITS_W'(cnt) * NBITS_W'(nb);
    end
  end

endmodule

### hdl/pbpp_fifo.sv
// Short queue between the front and back parts of the packer.
// Depends on pbpp_pkg for the entry type.
`timescale 1ns / 1ps

module pbpp_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pbpp_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output pbpp_pkg::entry_t pop_data,
  output logic             not_empty
);
  import pbpp_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;

  assign full      = (fill == CW'(DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### hdl/pbpp_back.sv
// Back part of the packer: merges queued bit words with pending bits, emits
// one byte per cycle to the output register unless stalled. Depends on pbpp_pkg.
`timescale 1ns / 1ps

module pbpp_back (
  input  logic              clk,
  input  logic              rst,
  input  pbpp_pkg::entry_t  q_entry,
  input  logic              q_valid,
  output logic              q_pop,
  output logic              result_valid,
  input  logic              result_stall,
  output pbpp_pkg::result_t result
);
  import pbpp_pkg::*;

  logic [BUF_W-1:0] bitbuf;
  logic [CNT_W-1:0] bit_cnt;
  logic             flush_pend;

  logic [BUF_W-1:0] bitbuf_next;
  logic [CNT_W-1:0] bit_cnt_next;
  logic             flush_pend_next;

  logic [BUF_W-1:0] vbuf;
  logic [CNT_W-1:0] vcnt;
  logic             vlast;
  logic             load;
  logic             can_emit;
  logic             emit;
  logic [7:0]       byte_val;
  logic             byte_last;

  always_comb begin
    load     = (bit_cnt < CNT_W'(BYTE_BITS)) && !flush_pend && q_valid;
    q_pop    = load;
    can_emit = !result_valid || !result_stall;
    if (load) begin
      vbuf  = (bitbuf << q_entry.nbits) | BUF_W'(q_entry.bits);
      vcnt  = bit_cnt + CNT_W'(q_entry.nbits);
      vlast = q_entry.last;
    end else begin
      vbuf  = bitbuf;
      vcnt  = bit_cnt;
      vlast = flush_pend;
    end
    emit            = can_emit && ((vcnt >= CNT_W'(BYTE_BITS)) || (vlast && vcnt != '0));
    bitbuf_next     = vbuf;
    bit_cnt_next    = vcnt;
    flush_pend_next = vlast;
    byte_val        = '0;
    byte_last       = 1'b0;
    if (vcnt >= CNT_W'(BYTE_BITS)) begin
      byte_val  = 8'(vbuf >> (vcnt - CNT_W'(BYTE_BITS)));
      byte_last = vlast && (vcnt == CNT_W'(BYTE_BITS));
      if (emit) begin
        bit_cnt_next    = vcnt - CNT_W'(BYTE_BITS);
        flush_pend_next = vlast && (vcnt != CNT_W'(BYTE_BITS));
      end
    end else begin
      byte_val  = vbuf[7:0] << (4'd8 - vcnt[3:0]);
      byte_last = 1'b1;
      if (emit || (vlast && vcnt == '0)) begin
        bit_cnt_next    = '0;
        flush_pend_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    bitbuf <= bitbuf_next;
    if (emit) begin
      result.packed_byte <= byte_val;
      result.last_byte   <= byte_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt      <= '0;
      flush_pend   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      bit_cnt    <= bit_cnt_next;
      flush_pend <= flush_pend_next;
      if (can_emit) begin
        result_valid <= emit;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    bit_cnt <= CNT_W'(BUF_W))
    else $error("bit count exceeds buffer width");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    emit && byte_last |=> bit_cnt == '0 && !flush_pend)
    else $error("state not cleared after final beat");

  a_flush_done: assert property (@(posedge clk) disable iff (rst)
    flush_pend && bit_cnt == '0 |=> !flush_pend)
    else $error("empty flush did not retire");

endmodule
